@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define ASSERT_CLKED(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/ogbd_pkg.sv @@
// Shared types, constants and functions of the occupancy grid downsampler.
`default_nettype none

package ogbd_pkg;

   localparam int MAX_WIDTH   = 4096;
   localparam int MAX_HEIGHT  = 4096;
   localparam int MAX_TILE    = 16;
   localparam int DIM_W       = 13;
   localparam int COORD_W     = 12;
   localparam int TILE_W      = 5;
   localparam int TILE_IDX_W  = 4;
   localparam int CELL_W      = 8;
   localparam int CLASS_W     = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 13;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 32;

   localparam logic signed [CELL_W-1:0] CELL_UNKNOWN = -8'sd1;

   localparam logic [CLASS_W-1:0] CLASS_FREE    = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_BLOCKED = 2'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAP_WIDTH     = 3'd0,
      CSR_MAP_HEIGHT    = 3'd1,
      CSR_BLOCK_SIZE    = 3'd2,
      CSR_BLOCKED_ABOVE = 3'd3,
      CSR_PAD_VALUE     = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [DIM_W-1:0]         map_width;
      logic [DIM_W-1:0]         map_height;
      logic [TILE_W-1:0]        block_size;
      logic signed [CELL_W-1:0] blocked_above;
      logic signed [CELL_W-1:0] pad_value;
   } cfg_type;

   // Per-beat result of the scan stage, carried into the flag stage.
   typedef struct packed {
      logic               seg_end;
      logic               use_mem;
      logic               emit;
      logic               pad_blocked;
      logic               run_flag;
      logic               map_end;
      logic [COORD_W-1:0] tile_col;
      logic [COORD_W-1:0] tile_row;
   } scan_type;

   function automatic logic is_blocked(logic signed [CELL_W-1:0] value,
                                       logic signed [CELL_W-1:0] thresh);
      return (value == CELL_UNKNOWN) || (value > thresh);
   endfunction

   function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v,
                                                  logic [DIM_W-1:0] hi);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [TILE_W-1:0] clamp_tile(logic [TILE_W-1:0] v);
      logic [TILE_W-1:0] r;
      if (v == '0) begin
         r = TILE_W'(1);
      end else if (v > TILE_W'(MAX_TILE)) begin
         r = TILE_W'(MAX_TILE);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/ogbd_scan.sv @@
// Raster position counters and per-cell tile bookkeeping.
`default_nettype none

module ogbd_scan (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire ogbd_pkg::cfg_type                cfg,
   input  wire                                   accept,
   input  wire logic signed [ogbd_pkg::CELL_W-1:0] cell_value,
   output ogbd_pkg::scan_type                    info
);

   logic [ogbd_pkg::COORD_W-1:0]    cell_col_ff, cell_col_in;
   logic [ogbd_pkg::COORD_W-1:0]    cell_row_ff, cell_row_in;
   logic [ogbd_pkg::TILE_IDX_W-1:0] col_in_tile_ff, col_in_tile_in;
   logic [ogbd_pkg::TILE_IDX_W-1:0] row_in_tile_ff, row_in_tile_in;
   logic [ogbd_pkg::COORD_W-1:0]    tile_col_ff, tile_col_in;
   logic [ogbd_pkg::COORD_W-1:0]    tile_row_ff, tile_row_in;
   logic                            running_ff, running_in;

   logic [ogbd_pkg::DIM_W-1:0]  w, h, col_nx, row_nx;
   logic [ogbd_pkg::TILE_W-1:0] bs, cit_nx, rit_nx;
   logic row_end, last_row, map_end, seg_end, tile_rows_end, padded, run;

   always_comb begin
      w        = ogbd_pkg::clamp_dim(cfg.map_width, ogbd_pkg::DIM_W'(ogbd_pkg::MAX_WIDTH));
      h        = ogbd_pkg::clamp_dim(cfg.map_height, ogbd_pkg::DIM_W'(ogbd_pkg::MAX_HEIGHT));
      bs       = ogbd_pkg::clamp_tile(cfg.block_size);
      col_nx   = {1'b0, cell_col_ff} + ogbd_pkg::DIM_W'(1);
      row_nx   = {1'b0, cell_row_ff} + ogbd_pkg::DIM_W'(1);
      cit_nx   = {1'b0, col_in_tile_ff} + ogbd_pkg::TILE_W'(1);
      rit_nx   = {1'b0, row_in_tile_ff} + ogbd_pkg::TILE_W'(1);
      row_end  = col_nx >= w;
      last_row = row_nx >= h;
      map_end  = row_end && last_row;
      seg_end  = row_end || (cit_nx >= bs);
      tile_rows_end = last_row || (rit_nx >= bs);
      padded   = (cit_nx < bs) || (rit_nx < bs);
      run      = running_ff | ogbd_pkg::is_blocked(cell_value, cfg.blocked_above);

      info.seg_end     = seg_end;
      info.use_mem     = row_in_tile_ff != '0;
      info.emit        = seg_end && tile_rows_end;
      info.pad_blocked = padded && ogbd_pkg::is_blocked(cfg.pad_value, cfg.blocked_above);
      info.run_flag    = run;
      info.map_end     = map_end;
      info.tile_col    = tile_col_ff;
      info.tile_row    = tile_row_ff;
   end

   always_comb begin
      cell_col_in    = cell_col_ff;
      cell_row_in    = cell_row_ff;
      col_in_tile_in = col_in_tile_ff;
      row_in_tile_in = row_in_tile_ff;
      tile_col_in    = tile_col_ff;
      tile_row_in    = tile_row_ff;
      running_in     = running_ff;
      if (accept) begin
         running_in = seg_end ? 1'b0 : run;
         if (map_end) begin
            cell_col_in    = '0;
            cell_row_in    = '0;
            col_in_tile_in = '0;
            row_in_tile_in = '0;
            tile_col_in    = '0;
            tile_row_in    = '0;
         end else if (row_end) begin
            cell_col_in    = '0;
            col_in_tile_in = '0;
            tile_col_in    = '0;
            cell_row_in    = row_nx[ogbd_pkg::COORD_W-1:0];
            if (rit_nx >= bs) begin
               row_in_tile_in = '0;
               tile_row_in    = tile_row_ff + ogbd_pkg::COORD_W'(1);
            end else begin
               row_in_tile_in = rit_nx[ogbd_pkg::TILE_IDX_W-1:0];
            end
         end else begin
            cell_col_in = col_nx[ogbd_pkg::COORD_W-1:0];
            if (seg_end) begin
               col_in_tile_in = '0;
               tile_col_in    = tile_col_ff + ogbd_pkg::COORD_W'(1);
            end else begin
               col_in_tile_in = cit_nx[ogbd_pkg::TILE_IDX_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_col_ff    <= '0;
         cell_row_ff    <= '0;
         col_in_tile_ff <= '0;
         row_in_tile_ff <= '0;
         tile_col_ff    <= '0;
         tile_row_ff    <= '0;
         running_ff     <= 1'b0;
      end else begin
         cell_col_ff    <= cell_col_in;
         cell_row_ff    <= cell_row_in;
         col_in_tile_ff <= col_in_tile_in;
         row_in_tile_ff <= row_in_tile_in;
         tile_col_ff    <= tile_col_in;
         tile_row_ff    <= tile_row_in;
         running_ff     <= running_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/occupancy_grid_block_downsample.sv @@
// A completing beat is registered in the flag stage, then its coarse cell in rsp registers.
// Throughput: one cell per cycle unless stalled; the tile flag memory is read on accept and
// written at segment end in the flag stage, with a bypass when both touch the same column.
// Input stalls only while a finished tile waits behind an unaccepted coarse cell.
// Reset clears counters, valid flags and configuration; the data registers and the flag
// memory are not cleared since each tile row's first row writes a flag before it is used.
`default_nettype none

`include "assert_macros.svh"

module occupancy_grid_block_downsample (
   input  wire                                   clock,
   input  wire                                   reset,
   // configuration writes
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire [ogbd_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire [ogbd_pkg::CSR_DATA_W-1:0]        csr_data,
   // cell stream
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   input  wire [ogbd_pkg::REQ_DATA_W-1:0]        req_tdata,  // [7:0] cell_value
   // coarse cell stream
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic [ogbd_pkg::RSP_DATA_W-1:0]       rsp_tdata,  // [1:0] coarse_class,
                                                             // [13:2] coarse_col,
                                                             // [25:14] coarse_row
   output logic                                  rsp_tlast   // map_done
);

   ogbd_pkg::cfg_type  cfg_ff;
   ogbd_pkg::scan_type info, s1_ff;

   logic s1_valid_ff, s1_valid_in;
   logic s1_adv, accept;
   logic byp_ff, byp_in, byp_data_ff;
   logic rd_q_ff, prior, acc;

   logic flag_mem [ogbd_pkg::MAX_WIDTH];

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ogbd_pkg::CLASS_W-1:0]    rsp_class_ff;
   logic [ogbd_pkg::COORD_W-1:0]    rsp_col_ff, rsp_row_ff;
   logic                            rsp_last_ff;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.map_width     <= ogbd_pkg::DIM_W'(1);
         cfg_ff.map_height    <= ogbd_pkg::DIM_W'(1);
         cfg_ff.block_size    <= ogbd_pkg::TILE_W'(1);
         cfg_ff.blocked_above <= 8'sd50;
         cfg_ff.pad_value     <= 8'sd100;
      end else if (csr_valid) begin
         case (ogbd_pkg::csr_index_type'(csr_index))
            ogbd_pkg::CSR_MAP_WIDTH:     cfg_ff.map_width     <= csr_data;
            ogbd_pkg::CSR_MAP_HEIGHT:    cfg_ff.map_height    <= csr_data;
            ogbd_pkg::CSR_BLOCK_SIZE:
               cfg_ff.block_size    <= csr_data[ogbd_pkg::TILE_W-1:0];
            ogbd_pkg::CSR_BLOCKED_ABOVE:
               cfg_ff.blocked_above <= csr_data[ogbd_pkg::CELL_W-1:0];
            ogbd_pkg::CSR_PAD_VALUE:
               cfg_ff.pad_value     <= csr_data[ogbd_pkg::CELL_W-1:0];
            default: ;
         endcase
      end
   end

   // scan stage
   assign s1_adv     = s1_valid_ff && (!s1_ff.emit || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign accept     = req_tvalid && req_tready;

   ogbd_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .accept     (accept),
      .cell_value (req_tdata[ogbd_pkg::CELL_W-1:0]),
      .info       (info)
   );

   // flag stage: read-modify-write of the per-column tile flag
   assign prior  = byp_ff ? byp_data_ff : rd_q_ff;
   assign acc    = s1_ff.run_flag | (s1_ff.use_mem & prior);
   assign byp_in = s1_adv && s1_ff.seg_end && (s1_ff.tile_col == info.tile_col);

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_q_ff <= flag_mem[info.tile_col];
      end
      if (s1_adv && s1_ff.seg_end) begin
         flag_mem[s1_ff.tile_col] <= acc;
      end
   end

   always_comb begin
      s1_valid_in  = accept || (s1_valid_ff && !s1_adv);
      rsp_valid_in = (s1_adv && s1_ff.emit) || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         byp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            byp_ff <= byp_in;
         end else if (s1_adv) begin
            byp_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff       <= info;
         byp_data_ff <= acc;
      end
      if (s1_adv && s1_ff.emit) begin
         rsp_class_ff <= (acc || s1_ff.pad_blocked) ? ogbd_pkg::CLASS_BLOCKED
                                                    : ogbd_pkg::CLASS_FREE;
         rsp_col_ff   <= s1_ff.tile_col;
         rsp_row_ff   <= s1_ff.tile_row;
         rsp_last_ff  <= s1_ff.map_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_row_ff, rsp_col_ff, rsp_class_ff};
   assign rsp_tlast  = rsp_last_ff;

   `ASSERT_CLKED(a_bypass_needs_item, clock, reset,
      byp_ff |-> s1_valid_ff, "bypass flag set with flag stage empty")
   `ASSERT_CLKED(a_accept_frees_stage, clock, reset,
      (accept && s1_valid_ff) |-> s1_adv, "cell accepted into an occupied flag stage")
   `ASSERT_CLKED(a_rsp_load_from_emit, clock, reset,
      (!rsp_valid_ff || rsp_tready) ##1 rsp_valid_ff |-> $past(s1_adv && s1_ff.emit),
      "coarse cell offered without an emitting tile")
   `ASSERT_ALWAYS(a_ready_in_reset, clock,
      reset |=> (req_tready && !rsp_tvalid), "stages not empty after reset")

endmodule

`default_nettype wire
